>>> src/svc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package svc_pkg;

    // request kinds carried in the low bit of tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // silhouette selectors
    localparam logic [1:0] VIEW_FRONT = 2'd0;
    localparam logic [1:0] VIEW_RIGHT = 2'd1;
    localparam logic [1:0] VIEW_UP    = 2'd2;

    // one query answer
    typedef struct packed {
        logic surface;
        logic occupied;
    } result_t;

    // depth of the answer queue
    localparam int RES_DEPTH = 2;

endpackage

`default_nettype wire

>>> src/svc_plane.sv
`timescale 1ns / 1ps
`default_nettype none

module svc_plane #(
    parameter int GRID = 128,
    localparam int AW = $clog2(GRID)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_row,
    input  wire logic [AW-1:0]   wr_col,
    input  wire logic            wr_bit,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_row,
    output logic      [GRID-1:0] rd_data
);

    logic [GRID-1:0] plane_mem [GRID];
    logic [GRID-1:0] rd_data_reg;

    // single port: bit write or whole row read, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            plane_mem[wr_row][wr_col] <= wr_bit;
        end
        else if (rd_en)
        begin
            rd_data_reg <= plane_mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/silhouette_voxel_carving.sv
`timescale 1ns / 1ps
`default_nettype none

// Visual hull of three GRID x GRID binary silhouettes (front, right, up), each held
// in a single-port row memory. A write request sets or clears one pixel. A query
// request reads rows x-1, x, x+1 of the front and right planes and rows z-1, z,
// z+1 of the up plane (only the centre rows for voxels on the grid boundary), one row
// per memory per cycle; no new request is taken until its reads are done. Writes
// are taken every cycle while no query is reading and under two answers are owed.
// The answer (occupied, surface) leaves through a two-entry output queue; requests
// stall while a query is reading or two answers are owed. Pixels never written
// read as undefined; out-of-grid writes are dropped, out-of-grid queries answer zero.
module silhouette_voxel_carving #(
    parameter int GRID = 128,
    localparam int CW = $clog2(GRID),
    localparam int TDATA_W = ((5 * CW + 1 + 7) / 8) * 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // pix_row, pix_col, pix_set, vox_x, vox_y, vox_z, zero fill
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    // func, view
    input  wire logic [2:0]         s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // occupied, surface, zero fill
    output logic [7:0]              m_axis_tdata
);

    localparam logic [CW-1:0] G_MAX = CW'(GRID - 1);
    localparam logic [CW-1:0] G_HI  = CW'(GRID - 2);
    localparam logic [CW-1:0] ONE   = CW'(1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CTR,
        PH_LOW,
        PH_HIGH
    } phase_t;

    // request fields
    logic          in_func;
    logic [1:0]    in_view;
    logic [CW-1:0] pix_row;
    logic [CW-1:0] pix_col;
    logic          pix_set;
    logic [CW-1:0] vox_x;
    logic [CW-1:0] vox_y;
    logic [CW-1:0] vox_z;

    assign in_func = s_axis_tuser[0];
    assign in_view = s_axis_tuser[2:1];
    assign pix_row = s_axis_tdata[CW-1:0];
    assign pix_col = s_axis_tdata[2*CW-1:CW];
    assign pix_set = s_axis_tdata[2*CW];
    assign vox_x   = s_axis_tdata[3*CW:2*CW+1];
    assign vox_y   = s_axis_tdata[4*CW:3*CW+1];
    assign vox_z   = s_axis_tdata[5*CW:4*CW+1];

    logic accept;
    logic wr_go;
    logic q_go;
    logic pop;
    logic in_grid;
    logic interior;

    phase_t     phase_reg, phase_next;
    phase_t     rd_tag_reg;
    logic [1:0] pend_reg, pend_next;

    // held query, out-of-grid coordinates replaced by zero
    logic [CW-1:0] qx_reg;
    logic [CW-1:0] qy_reg;
    logic [CW-1:0] qz_reg;
    logic          qin_reg;
    logic          qint_reg;

    assign accept   = s_axis_tvalid & s_axis_tready;
    assign wr_go    = accept & (in_func == svc_pkg::FUNC_WRITE)
                      & (pix_row <= G_MAX) & (pix_col <= G_MAX);
    assign q_go     = accept & (in_func == svc_pkg::FUNC_QUERY);
    assign in_grid  = (vox_x <= G_MAX) & (vox_y <= G_MAX) & (vox_z <= G_MAX);
    assign interior = (vox_x >= ONE) & (vox_x <= G_HI) & (vox_y >= ONE) & (vox_y <= G_HI)
                      & (vox_z >= ONE) & (vox_z <= G_HI);

    assign s_axis_tready = (phase_reg == PH_IDLE) & (pend_reg < 2'(svc_pkg::RES_DEPTH));

    // read sequencer: centre row on acceptance, then lower and upper rows
    always_comb
    begin
        case (phase_reg)
            PH_IDLE: phase_next = q_go ? PH_LOW : PH_IDLE;
            PH_LOW:  phase_next = PH_HIGH;
            PH_HIGH: phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // queries taken but not yet delivered
    always_comb
    begin
        case ({q_go, pop})
            2'b10:   pend_next = pend_reg + 2'd1;
            2'b01:   pend_next = pend_reg - 2'd1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            rd_tag_reg <= PH_IDLE;
            pend_reg   <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            rd_tag_reg <= q_go ? PH_CTR : phase_reg;
            pend_reg   <= pend_next;
        end
    end

    // capture the query
    always_ff @(posedge clk)
    begin
        if (q_go)
        begin
            qx_reg   <= (vox_x <= G_MAX) ? vox_x : '0;
            qy_reg   <= (vox_y <= G_MAX) ? vox_y : '0;
            qz_reg   <= (vox_z <= G_MAX) ? vox_z : '0;
            qin_reg  <= in_grid;
            qint_reg <= interior;
        end
    end

    // row addresses for the planes
    logic [CW-1:0] xz_row;
    logic [CW-1:0] z_row;
    logic          rd_en;

    always_comb
    begin
        xz_row = qx_reg;
        z_row  = qz_reg;
        if (q_go)
        begin
            xz_row = (vox_x <= G_MAX) ? vox_x : '0;
            z_row  = (vox_z <= G_MAX) ? vox_z : '0;
        end
        else if (phase_reg == PH_LOW && qint_reg)
        begin
            xz_row = qx_reg - ONE;
            z_row  = qz_reg - ONE;
        end
        else if (phase_reg == PH_HIGH && qint_reg)
        begin
            xz_row = qx_reg + ONE;
            z_row  = qz_reg + ONE;
        end
    end

    assign rd_en = q_go | (phase_reg != PH_IDLE);

    logic [GRID-1:0] f_row;
    logic [GRID-1:0] r_row;
    logic [GRID-1:0] u_row;

    svc_plane #(.GRID(GRID)) u_front (
        .clk     (clk),
        .wr_en   (wr_go & (in_view == svc_pkg::VIEW_FRONT)),
        .wr_row  (pix_row),
        .wr_col  (pix_col),
        .wr_bit  (pix_set),
        .rd_en   (rd_en),
        .rd_row  (xz_row),
        .rd_data (f_row)
    );

    svc_plane #(.GRID(GRID)) u_right (
        .clk     (clk),
        .wr_en   (wr_go & (in_view == svc_pkg::VIEW_RIGHT)),
        .wr_row  (pix_row),
        .wr_col  (pix_col),
        .wr_bit  (pix_set),
        .rd_en   (rd_en),
        .rd_row  (xz_row),
        .rd_data (r_row)
    );

    svc_plane #(.GRID(GRID)) u_up (
        .clk     (clk),
        .wr_en   (wr_go & (in_view == svc_pkg::VIEW_UP)),
        .wr_row  (pix_row),
        .wr_col  (pix_col),
        .wr_bit  (pix_set),
        .rd_en   (rd_en),
        .rd_row  (z_row),
        .rd_data (u_row)
    );

    // bit positions inside the returned rows
    logic [CW-1:0] y_lo;
    logic [CW-1:0] y_hi;
    logic [CW-1:0] rc;
    logic [CW-1:0] rc_zlo;
    logic [CW-1:0] rc_zhi;

    always_comb
    begin
        rc     = G_MAX - qz_reg;
        y_lo   = qint_reg ? qy_reg - ONE : qy_reg;
        y_hi   = qint_reg ? qy_reg + ONE : qy_reg;
        rc_zlo = qint_reg ? rc + ONE : rc;
        rc_zhi = qint_reg ? rc - ONE : rc;
    end

    // pixels gathered from the centre and lower rows
    logic f0c_reg, f0m_reg, f0p_reg;
    logic r0c_reg, r0zm_reg, r0zp_reg;
    logic u0c_reg, u0m_reg, u0p_reg;
    logic fm_reg, rm_reg, um_reg;

    always_ff @(posedge clk)
    begin
        if (rd_tag_reg == PH_CTR)
        begin
            f0c_reg  <= f_row[qy_reg];
            f0m_reg  <= f_row[y_lo];
            f0p_reg  <= f_row[y_hi];
            r0c_reg  <= r_row[rc];
            r0zm_reg <= r_row[rc_zlo];
            r0zp_reg <= r_row[rc_zhi];
            u0c_reg  <= u_row[qy_reg];
            u0m_reg  <= u_row[y_lo];
            u0p_reg  <= u_row[y_hi];
        end
        if (rd_tag_reg == PH_LOW)
        begin
            fm_reg <= f_row[qy_reg];
            rm_reg <= r_row[rc];
            um_reg <= u_row[qy_reg];
        end
    end

    // combine with the upper rows into the answer
    logic             ctr_full;
    logic             all_full;
    svc_pkg::result_t res;
    logic             push;

    always_comb
    begin
        ctr_full = f0c_reg & r0c_reg & u0c_reg;
        all_full = (fm_reg & rm_reg & u0c_reg)
                 & (f_row[qy_reg] & r_row[rc] & u0c_reg)
                 & (f0m_reg & r0c_reg & u0m_reg)
                 & (f0p_reg & r0c_reg & u0p_reg)
                 & (f0c_reg & r0zm_reg & um_reg)
                 & (f0c_reg & r0zp_reg & u_row[qy_reg]);
        res.occupied = qin_reg & ctr_full;
        res.surface  = qint_reg & ctr_full & ~all_full;
    end

    assign push = (rd_tag_reg == PH_HIGH);

    // answer queue
    svc_pkg::result_t res_mem [svc_pkg::RES_DEPTH];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       cnt_reg, cnt_next;

    assign pop = m_axis_tvalid & m_axis_tready;

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_mem[wptr_reg] <= res;
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {6'd0, res_mem[rptr_reg].surface, res_mem[rptr_reg].occupied};

endmodule

`default_nettype wire
